@@ sv/ipv6p_pkg.sv @@
// Package: shared types and constants for the IPv6 text address parser.
package ipv6p_pkg;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [3:0] NoGap   = 4'd8;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } req_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        status;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [8:0] dec_next(input logic [8:0] v, input logic [3:0] d);
    logic [12:0] t;
    t = {v, 3'b000} + {2'b00, v, 1'b0} + {9'd0, d};
    return (t > 13'd255) ? 9'd256 : t[8:0];
  endfunction
endpackage

@@ sv/ipv6_text_address_parser.sv @@
// Top level: IPv6 text address parser with stream ports.
// One character request is taken per cycle while the queue has room; a two-entry
// queue sits in front of the parse engine, which updates its registered state for
// each character it takes. The terminator request (s_axis_tlast) is held in a queue
// entry, and its result then in the output register. While a result waits on
// m_axis_tready the parse engine holds, so s_axis_tready drops once the queue holds
// two requests. Errors give status 1 and a zero address.
module ipv6_text_address_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // ch[7:0]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // addr_high[63:0], addr_low[127:64], status[128]
);
  ipv6p_pkg::req_t in_req, q_req;
  ipv6p_pkg::res_t res;
  logic            q_valid, q_ready;

  assign in_req.ch     = s_axis_tdata;
  assign in_req.is_end = s_axis_tlast;

  ipv6p_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  ipv6p_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tdata = {7'd0, res.status, res.addr_low, res.addr_high};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[128] |-> m_axis_tdata[127:0] == 128'd0)
    else $error("error result carries nonzero address");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule

@@ sv/ipv6p_front.sv @@
// Front end: accepts request characters into a short queue.
module ipv6p_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ipv6p_pkg::req_t in_req,
  output logic            q_valid,
  input  logic            q_ready,
  output ipv6p_pkg::req_t q_req
);
  ipv6p_pkg::req_t mem_r [ipv6p_pkg::QDepth];
  logic            wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready = cnt_r != 2'd2;
  assign q_valid  = cnt_r != 2'd0;
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= in_req;
    end
  end
endmodule

@@ sv/ipv6p_back.sv @@
// Back end: runs the parse state and emits the address on the terminator.
module ipv6p_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  ipv6p_pkg::req_t q_req,
  output logic            out_valid,
  input  logic            out_ready,
  output ipv6p_pkg::res_t out_res
);
  logic [15:0] gs_r [8];
  logic [15:0] gs_nxt [8];
  logic [3:0]  gc_r, gc_nxt, gp_r, gp_nxt;
  logic [15:0] hv_r, hv_nxt;
  logic        ho_r, ho_nxt, ds_r, ds_nxt, od_r, od_nxt, v4_r, v4_nxt;
  logic        st_r, st_nxt, er_r, er_nxt;
  logic [8:0]  dv_r, dv_nxt;
  logic [2:0]  oc_r, oc_nxt;
  logic        ov_r, ov_nxt;
  ipv6p_pkg::res_t res_r, res_nxt;
  logic        take;
  logic [3:0]  slots;
  logic        ok, commit_ok;
  ipv6p_pkg::hex_t h;
  logic [15:0] g [8];
  logic [15:0] fs [8];
  logic [3:0]  fgc, gpe, zeros, sidx;
  logic [7:0]  c;

  assign q_ready   = !ov_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign c         = q_req.ch;
  assign h         = ipv6p_pkg::hex_digit(c);
  assign slots     = gc_r + ((gp_r < ipv6p_pkg::NoGap) ? 4'd1 : 4'd0);
  assign commit_ok = !ho_r && slots < 4'd8;

  always_comb begin
    gs_nxt = gs_r;
    gc_nxt = gc_r; gp_nxt = gp_r; hv_nxt = hv_r; ho_nxt = ho_r; ds_nxt = ds_r;
    od_nxt = od_r; v4_nxt = v4_r; st_nxt = st_r; er_nxt = er_r; dv_nxt = dv_r;
    oc_nxt = oc_r;
    ov_nxt = ov_r && !out_ready;
    res_nxt = res_r;
    ok = 1'b0;
    fs = gs_r;
    fgc = gc_r;
    for (int i = 0; i < 8; i++) g[i] = 16'd0;
    gpe = 4'd0; zeros = 4'd0; sidx = 4'd0;
    if (take && q_req.is_end) begin
      if (er_r) ok = 1'b0;
      else if (v4_r) begin
        ok = ds_r && dv_r <= 9'd255 && oc_r == 3'd3;
        fs[gc_r[2:0] + 3'd1][7:0] = dv_r[7:0];
        fgc = gc_r + 4'd2;
      end else if (ds_r) begin
        ok = commit_ok;
        fs[gc_r[2:0]] = hv_r;
        fgc = gc_r + 4'd1;
      end else if (st_r) ok = 1'b0;
      else ok = gp_r < ipv6p_pkg::NoGap && gp_r == gc_r;
      if (ok) ok = (gp_r >= ipv6p_pkg::NoGap) ? (fgc == 4'd8) : (fgc <= 4'd7);
      gpe = (gp_r > fgc) ? fgc : gp_r;
      zeros = 4'd8 - fgc;
      for (int i = 0; i < 8; i++) begin
        sidx = 4'(i) - zeros;
        if (4'(i) < gpe) g[i] = fs[i];
        else if (4'(i) < gpe + zeros) g[i] = 16'd0;
        else g[i] = fs[sidx[2:0]];
        if (!ok) g[i] = 16'd0;
      end
      res_nxt.addr_high = {g[0], g[1], g[2], g[3]};
      res_nxt.addr_low  = {g[4], g[5], g[6], g[7]};
      res_nxt.status    = !ok;
      ov_nxt = 1'b1;
      for (int i = 0; i < 8; i++) gs_nxt[i] = 16'd0;
      gc_nxt = 4'd0; gp_nxt = ipv6p_pkg::NoGap; hv_nxt = 16'd0; ho_nxt = 1'b0;
      ds_nxt = 1'b0; dv_nxt = 9'd0; od_nxt = 1'b1; v4_nxt = 1'b0; oc_nxt = 3'd0;
      st_nxt = 1'b1; er_nxt = 1'b0;
    end else if (take && !er_r) begin
      if (v4_r) begin
        if (c >= 8'h30 && c <= 8'h39) begin
          dv_nxt = ipv6p_pkg::dec_next(dv_r, c[3:0]);
          ds_nxt = 1'b1;
        end else if (c == ipv6p_pkg::ChDot && ds_r && dv_r <= 9'd255 && oc_r < 3'd3) begin
          if (!oc_r[0]) gs_nxt[gc_r[2:0] + {2'b00, oc_r[1]}][15:8] = dv_r[7:0];
          else gs_nxt[gc_r[2:0] + {2'b00, oc_r[1]}][7:0] = dv_r[7:0];
          oc_nxt = oc_r + 3'd1;
          ds_nxt = 1'b0;
          dv_nxt = 9'd0;
        end else er_nxt = 1'b1;
      end else if (ds_r) begin
        if (h.valid) begin
          if (hv_r > 16'h0fff) ho_nxt = 1'b1;
          hv_nxt = {hv_r[11:0], h.value};
          if (h.value < 4'd10 && od_r) dv_nxt = ipv6p_pkg::dec_next(dv_r, h.value);
          else od_nxt = 1'b0;
        end else if (c == ipv6p_pkg::ChColon) begin
          if (commit_ok) begin
            gs_nxt[gc_r[2:0]] = hv_r;
            gc_nxt = gc_r + 4'd1;
            hv_nxt = 16'd0;
            ds_nxt = 1'b0;
          end else er_nxt = 1'b1;
        end else if (c == ipv6p_pkg::ChDot && od_r && dv_r <= 9'd255 && slots <= 4'd6) begin
          v4_nxt = 1'b1;
          gs_nxt[gc_r[2:0]][15:8] = dv_r[7:0];
          oc_nxt = 3'd1;
          ds_nxt = 1'b0;
          dv_nxt = 9'd0;
        end else er_nxt = 1'b1;
      end else begin
        if (h.valid) begin
          st_nxt = 1'b0;
          ds_nxt = 1'b1;
          hv_nxt = {12'd0, h.value};
          ho_nxt = 1'b0;
          od_nxt = h.value < 4'd10;
          dv_nxt = (h.value < 4'd10) ? {5'd0, h.value} : 9'd0;
        end else if (c == ipv6p_pkg::ChColon) begin
          if (st_r) st_nxt = 1'b0;
          else if (gp_r < ipv6p_pkg::NoGap || slots >= 4'd8) er_nxt = 1'b1;
          else gp_nxt = gc_r;
        end else er_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) gs_r[i] <= 16'd0;
      gc_r <= 4'd0; gp_r <= ipv6p_pkg::NoGap; hv_r <= 16'd0; ho_r <= 1'b0;
      ds_r <= 1'b0; dv_r <= 9'd0; od_r <= 1'b1; v4_r <= 1'b0; oc_r <= 3'd0;
      st_r <= 1'b1; er_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      gs_r <= gs_nxt;
      gc_r <= gc_nxt; gp_r <= gp_nxt; hv_r <= hv_nxt; ho_r <= ho_nxt;
      ds_r <= ds_nxt; dv_r <= dv_nxt; od_r <= od_nxt; v4_r <= v4_nxt; oc_r <= oc_nxt;
      st_r <= st_nxt; er_r <= er_nxt; ov_r <= ov_nxt;
    end
    res_r <= res_nxt;
  end
endmodule

@@ bench/tb.sv @@
// Testbench: IPv6 text address parser, predicted results against stream output.
module tb;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        st;
  } addr_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [7:0]   in_data;   // ch[7:0]
  logic         in_last;
  logic         out_valid;
  logic         out_ready;
  logic [135:0] out_data;  // addr_high[63:0], addr_low[127:64], status[128]

  ipv6_text_address_parser dut (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
    .s_axis_tdata(in_data), .s_axis_tlast(in_last),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
    .m_axis_tdata(out_data)
  );

  // predictor state
  logic [15:0] grp [8];
  logic [3:0]  gcnt;
  logic [3:0]  gpos;
  logic [15:0] hval;
  logic        hovf;
  logic        dseen;
  logic [8:0]  dval;
  logic        onlydec;
  logic        v4;
  logic [2:0]  v4cnt;
  logic        atstart;
  logic        err;

  addr_res_t expq[$];
  int errors;
  int results;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic pred_reset();
    for (int i = 0; i < 8; i++) grp[i] = 16'h0;
    gcnt = 0; gpos = ipv6p_pkg::NoGap; hval = 0; hovf = 0; dseen = 0; dval = 0;
    onlydec = 1; v4 = 0; v4cnt = 0; atstart = 1; err = 0;
  endtask

  function automatic int slots();
    return int'(gcnt) + (gpos < ipv6p_pkg::NoGap ? 1 : 0);
  endfunction

  function automatic int hexval(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic logic [8:0] dec_acc(logic [8:0] v, int d);
    int t;
    t = int'(v) * 10 + d;
    return t > 255 ? 9'd256 : t[8:0];
  endfunction

  task automatic put_octet(int idx, logic [8:0] val);
    int g;
    g = (int'(gcnt) + ((idx & 3) >> 1)) & 7;
    if ((idx & 1) == 0) grp[g][15:8] = val[7:0];
    else grp[g][7:0] = val[7:0];
  endtask

  task automatic commit(output bit ok);
    ok = 0;
    if (!hovf && slots() < 8) begin
      grp[gcnt[2:0]] = hval;
      gcnt++;
      hval = 0;
      dseen = 0;
      ok = 1;
    end
  endtask

  task automatic close_text(output bit ok);
    bit c;
    ok = 0;
    if (err) return;
    if (v4) begin
      if (!dseen || dval > 255 || v4cnt != 3) return;
      put_octet(3, dval);
      gcnt = gcnt + 2;
    end else if (dseen) begin
      commit(c);
      if (!c) return;
    end else if (atstart) begin
      return;
    end else if (!(gpos < ipv6p_pkg::NoGap && gpos == gcnt)) begin
      return;
    end
    ok = (gpos >= ipv6p_pkg::NoGap) ? (gcnt == 8) : (gcnt <= 7);
  endtask

  task automatic predict_char(logic [7:0] c, logic last);
    addr_res_t r;
    logic [15:0] g [8];
    int gp, zeros, k, h;
    bit ok, c2;
    if (last) begin
      close_text(ok);
      r = '0;
      if (ok) begin
        gp = gpos < ipv6p_pkg::NoGap ? int'(gpos) : 8;
        zeros = 8 - int'(gcnt);
        if (gp > gcnt) gp = gcnt;
        k = 0;
        for (int i = 0; i < 8; i++) begin
          if (i < gp) g[i] = grp[i];
          else if (i < gp + zeros) g[i] = 0;
          else begin
            g[i] = grp[(gp + k) & 7];
            k++;
          end
        end
        r.hi = {g[0], g[1], g[2], g[3]};
        r.lo = {g[4], g[5], g[6], g[7]};
      end
      r.st = !ok;
      expq.push_back(r);
      pred_reset();
      return;
    end
    if (err) return;
    h = hexval(c);
    if (v4) begin
      if (c >= "0" && c <= "9") begin
        dval = dec_acc(dval, c - "0");
        dseen = 1;
      end else if (c == ipv6p_pkg::ChDot && dseen && dval <= 255 && v4cnt < 3) begin
        put_octet(v4cnt, dval);
        v4cnt++;
        dseen = 0;
        dval = 0;
      end else err = 1;
    end else if (dseen) begin
      if (h >= 0) begin
        if (hval > 16'h0fff) hovf = 1;
        hval = {hval[11:0], 4'(h)};
        if (h < 10 && onlydec) dval = dec_acc(dval, h);
        else onlydec = 0;
      end else if (c == ipv6p_pkg::ChColon) begin
        commit(c2);
        if (!c2) err = 1;
      end else if (c == ipv6p_pkg::ChDot && onlydec && dval <= 255 && slots() <= 6) begin
        v4 = 1;
        put_octet(0, dval);
        v4cnt = 1;
        dseen = 0;
        dval = 0;
      end else err = 1;
    end else begin
      if (h >= 0) begin
        atstart = 0; dseen = 1; hval = 16'(h); hovf = 0;
        onlydec = h < 10;
        dval = h < 10 ? 9'(h) : 9'd0;
      end else if (c == ipv6p_pkg::ChColon) begin
        if (atstart) atstart = 0;
        else if (gpos < ipv6p_pkg::NoGap || slots() >= 8) err = 1;
        else gpos = gcnt;
      end else err = 1;
    end
  endtask

  task automatic send(logic [7:0] c, logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= c;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 0);
    send(8'h00, 1);
  endtask

  function automatic string hex_group();
    string s, d;
    int n;
    d = "0123456789abcdefABCDEF";
    s = "";
    n = $urandom_range(4, 1);
    if ($urandom_range(19) == 0) n = $urandom_range(6, 5);
    for (int i = 0; i < n; i++) s = {s, string'(d[$urandom_range(21)])};
    return s;
  endfunction

  function automatic string quad();
    string s;
    for (int i = 0; i < 4; i++) begin
      s = {s, $sformatf("%0d", $urandom_range(19) == 0 ? $urandom_range(999) :
                                $urandom_range(255))};
      if (i < 3) s = {s, "."};
    end
    return s;
  endfunction

  function automatic string rand_text();
    string s;
    int n, gap, use4;
    n = $urandom_range(8, 1);
    gap = $urandom_range(2) == 0 ? -1 : $urandom_range(n);
    use4 = $urandom_range(4) == 0;
    s = "";
    if (gap == 0) s = "::";
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, (gap == i) ? "::" : ":"};
      if (use4 && i == n - 1) s = {s, quad()};
      else s = {s, hex_group()};
    end
    if (gap == n && n > 0) s = {s, "::"};
    return s;
  endfunction

  task automatic send_random(int pct_noise);
    string s;
    int k, m;
    if ($urandom_range(99) < pct_noise) begin
      m = $urandom_range(12);
      for (int i = 0; i < m; i++) send(8'($urandom_range(255)), 0);
      send(8'($urandom_range(255)), 1);
      return;
    end
    s = rand_text();
    if ($urandom_range(9) == 0 && s.len() > 0) begin
      k = $urandom_range(s.len() - 1);
      s[k] = 8'($urandom_range(255));
    end
    for (int i = 0; i < s.len(); i++) send(s[i], 0);
    send(8'($urandom_range(255)), 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expq.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_off &&
                   !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // output checker
  always @(posedge clk) begin
    addr_res_t got, exp;
    if (rst_n && out_valid && out_ready) begin
      got = out_data[128:0];
      got.hi = out_data[63:0];
      got.lo = out_data[127:64];
      got.st = out_data[128];
      results++;
      if (expq.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        errors++;
      end else begin
        exp = expq.pop_front();
        if (got.hi !== exp.hi) begin
          $error("addr_high expected %h actual %h", exp.hi, got.hi); errors++;
        end
        if (got.lo !== exp.lo) begin
          $error("addr_low expected %h actual %h", exp.lo, got.lo); errors++;
        end
        if (got.st !== exp.st) begin
          $error("status expected %0d actual %0d", exp.st, got.st); errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  typedef struct {
    string     txt;
    bit        known;
    addr_res_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];
  addr_res_t bad;

  initial begin
    rst_n = 0; in_valid = 0; in_data = 0; in_last = 0;
    hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0;
    errors = 0; results = 0;
    bad = '{64'h0, 64'h0, 1'b1};
    pred_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    dir_rows = '{
      '{"", 1, bad},
      '{":", 1, bad},
      '{"::", 1, '{64'h0, 64'h0, 1'b0}},
      '{"ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff", 1,
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0}},
      '{"0:0:0:0:0:0:0:0", 1, '{64'h0, 64'h0, 1'b0}},
      '{"::1", 1, '{64'h0, 64'h1, 1'b0}},
      '{"1::", 0, bad}, '{":1::2", 0, bad},
      '{"1:2:3:4:5:6:7::", 0, bad},
      '{"1:2:3:4:5:6:7:8::", 1, bad},
      '{"1:2:3:4:5:6:7", 1, bad},
      '{"1:2:3:4:5:6:7:8:9", 1, bad},
      '{"10000::", 1, bad},
      '{"000000ABcd::", 0, bad},
      '{"1::2::3", 1, bad},
      '{"1:2:", 1, bad},
      '{"1 ::", 1, bad}, '{"+1::", 1, bad}, '{"0x1::", 1, bad},
      '{"::ffff:192.168.0.1", 0, bad},
      '{"1:2:3:4:5:6:255.255.255.255", 0, bad},
      '{"1:2:3:4:5:6:7:1.2.3.4", 1, bad},
      '{"::1.2.3.256", 1, bad}, '{"::1.2.3", 1, bad},
      '{"::001.02.3.4.", 1, bad}
    };
    foreach (dir_rows[i]) begin
      send_text(dir_rows[i].txt);
      if (dir_rows[i].known) expq[expq.size() - 1] = dir_rows[i].res;
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 36 : 60) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 36 : 60) : 0;
      for (int n = 0; n < 14; n++) send_random(15);
      drain();
    end

    // long receiver hold-off with the sender still offering requests
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int n = 0; n < 20; n++) send_text("::");
    join
    drain();

    for (int n = 0; n < 16; n++) send_random(15);
    drain();

    $display("covered %0d addresses: directed extremes, gaps, quads, errors", results);
    $display("random texts under four idling mixes and a long output hold-off");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
